@@ design/i2cm_pkg.sv @@
// Shared types, command and line action codes, and step tables for the I2C master byte engine.
// No dependencies; every other design file imports this package.
package i2cm_pkg;

    localparam int unsigned I2CM_QUEUE_DEPTH = 2;
    localparam logic [7:0] PHASE_LEN_RESET = 8'd20;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] OP_IDLE   = 3'd0;

    localparam logic [2:0] ACT_SDA_H   = 3'd0;
    localparam logic [2:0] ACT_SDA_L   = 3'd1;
    localparam logic [2:0] ACT_SCL_H   = 3'd2;
    localparam logic [2:0] ACT_SCL_L   = 3'd3;
    localparam logic [2:0] ACT_SDA_BIT = 3'd4;
    localparam logic [2:0] ACT_SDA_ACK = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       scl_in;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_byte;
        logic       cmd_refused;
    } i2cm_out_t;

    typedef struct packed {
        logic [2:0] op;
        logic       is_cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       scl_in;
        logic       sda_in;
    } i2cm_entry_t;

    function automatic logic [3:0] step_count(input logic [2:0] op);
        logic [3:0] n;
        unique case (op)
            CMD_START: n = 4'd4;
            CMD_STOP:  n = 4'd4;
            CMD_WRITE: n = 4'd6;
            CMD_READ:  n = 4'd7;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] action_of(input logic [2:0] op, input logic [2:0] step);
        logic [2:0] a;
        a = ACT_SDA_H;
        if ({1'b0, step} < step_count(op)) begin
            unique case (op)
                CMD_START: begin
                    unique case (step)
                        3'd0:    a = ACT_SDA_H;
                        3'd1:    a = ACT_SCL_H;
                        3'd2:    a = ACT_SDA_L;
                        default: a = ACT_SCL_L;
                    endcase
                end
                CMD_STOP: begin
                    unique case (step)
                        3'd0:    a = ACT_SCL_L;
                        3'd1:    a = ACT_SDA_L;
                        3'd2:    a = ACT_SCL_H;
                        default: a = ACT_SDA_H;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (step)
                        3'd0:    a = ACT_SDA_BIT;
                        3'd1:    a = ACT_SCL_H;
                        3'd2:    a = ACT_SCL_L;
                        3'd3:    a = ACT_SDA_H;
                        3'd4:    a = ACT_SCL_H;
                        default: a = ACT_SCL_L;
                    endcase
                end
                default: begin
                    unique case (step)
                        3'd0:    a = ACT_SDA_H;
                        3'd1:    a = ACT_SCL_H;
                        3'd2:    a = ACT_SCL_L;
                        3'd3:    a = ACT_SDA_ACK;
                        3'd4:    a = ACT_SCL_H;
                        3'd5:    a = ACT_SCL_L;
                        default: a = ACT_SDA_H;
                    endcase
                end
            endcase
        end
        return a;
    endfunction

endpackage

@@ design/i2cm_front.sv @@
// Input side of the I2C master byte engine: accepts transactions and classifies the command.
// Depends on i2cm_pkg.
module i2cm_front import i2cm_pkg::*; (
    input  logic        s_valid,
    output logic        s_ready,
    input  i2cm_in_t    s_data,
    input  logic        q_full,
    output logic        q_push,
    output i2cm_entry_t q_entry
);

    logic is_cmd;

    assign is_cmd = (s_data.cmd >= CMD_START) && (s_data.cmd <= CMD_READ);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_entry.op        = is_cmd ? s_data.cmd : CMD_TICK;
        q_entry.is_cmd    = is_cmd;
        q_entry.data_byte = s_data.data_byte;
        q_entry.last_byte = s_data.last_byte;
        q_entry.scl_in    = s_data.scl_in;
        q_entry.sda_in    = s_data.sda_in;
    end

endmodule

@@ design/i2cm_queue.sv @@
// Short queue of classified entries between the front and the bus sequencer.
// Depends on i2cm_pkg.
module i2cm_queue import i2cm_pkg::*; #(
    parameter int unsigned DEPTH = I2CM_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  i2cm_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output i2cm_entry_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    i2cm_entry_t   slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/i2cm_back.sv @@
// Bus sequencer of the I2C master byte engine: runs the line phases and holds the result register.
// Depends on i2cm_pkg.
module i2cm_back import i2cm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  phase_len,
    input  logic        q_valid,
    input  i2cm_entry_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output i2cm_out_t   m_data
);

    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [2:0] op_reg, op_next;
    logic [2:0] step_reg, step_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] hold_reg, hold_next;
    logic       ack_reg, ack_next;
    logic       nack_reg, nack_next;
    logic       m_valid_reg;
    i2cm_out_t  m_data_reg, res;

    logic       fire;
    logic [7:0] hlen, hc;
    logic [2:0] act_cur, act_new, enter_step;
    logic       enter;
    logic [3:0] nxt, bit_inc;

    assign fire    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign hlen    = (phase_len == 8'd0) ? 8'd1 : phase_len;

    always_comb begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        ack_next   = ack_reg;
        nack_next  = nack_reg;
        res        = '0;
        enter      = 1'b0;
        enter_step = 3'd0;
        act_cur    = action_of(op_reg, step_reg);
        act_new    = ACT_SDA_H;
        hc         = hold_reg;
        nxt        = {1'b0, step_reg} + 4'd1;
        bit_inc    = bit_reg + 4'd1;

        if (op_reg != OP_IDLE) begin
            res.cmd_refused = q_head.is_cmd;
            if (act_cur == ACT_SCL_H && hc == 8'd0 && q_head.scl_in) begin
                hc = hlen;
            end
            if (hc != 8'd0) begin
                hc = hc - 8'd1;
                if (hc == 8'd0) begin
                    if (op_reg == CMD_WRITE) begin
                        if (step_reg == 3'd0) begin
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        if (step_reg == 3'd2) begin
                            bit_next = bit_inc;
                            if (bit_inc < 4'd8) begin
                                nxt = 4'd0;
                            end
                        end
                        if (step_reg == 3'd4) begin
                            ack_next = !q_head.sda_in;
                        end
                    end else if (op_reg == CMD_READ) begin
                        if (step_reg == 3'd1) begin
                            shift_next = {shift_reg[6:0], q_head.sda_in};
                        end
                        if (step_reg == 3'd2) begin
                            bit_next = bit_inc;
                            if (bit_inc < 4'd8) begin
                                nxt = 4'd1;
                            end
                        end
                    end
                    if (nxt >= step_count(op_reg)) begin
                        res.done_res  = 1'b1;
                        res.ack_ok    = (op_reg == CMD_WRITE) ? ack_next : 1'b0;
                        res.read_byte = (op_reg == CMD_READ) ? shift_next : 8'd0;
                        op_next       = OP_IDLE;
                        step_next     = 3'd0;
                        bit_next      = 4'd0;
                    end else begin
                        enter      = 1'b1;
                        enter_step = nxt[2:0];
                    end
                end
            end
            hold_next = hc;
        end else if (q_head.is_cmd) begin
            op_next    = q_head.op;
            bit_next   = 4'd0;
            ack_next   = 1'b0;
            shift_next = (q_head.op == CMD_WRITE) ? q_head.data_byte : 8'd0;
            if (q_head.op == CMD_READ) begin
                nack_next = q_head.last_byte;
            end
            enter      = 1'b1;
            enter_step = 3'd0;
        end

        if (enter) begin
            step_next = enter_step;
            act_new   = action_of(op_next, enter_step);
            unique case (act_new)
                ACT_SDA_H:   sda_next = 1'b0;
                ACT_SDA_L:   sda_next = 1'b1;
                ACT_SCL_H:   scl_next = 1'b0;
                ACT_SCL_L:   scl_next = 1'b1;
                ACT_SDA_BIT: sda_next = !shift_next[7];
                default:     sda_next = !nack_next;
            endcase
            hold_next = (act_new == ACT_SCL_H) ? 8'd0 : hlen;
        end

        res.scl_low  = scl_next;
        res.sda_low  = sda_next;
        res.busy_res = (op_next != OP_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_reg     <= 1'b0;
            sda_reg     <= 1'b0;
            op_reg      <= OP_IDLE;
            step_reg    <= 3'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            hold_reg    <= 8'd0;
            ack_reg     <= 1'b0;
            nack_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                op_reg    <= op_next;
                step_reg  <= step_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                hold_reg  <= hold_next;
                ack_reg   <= ack_next;
                nack_reg  <= nack_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res;
        end
    end

endmodule

@@ design/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: front classifier, entry queue and bus sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
// The engine takes one transaction per clock while its entry queue is not full and returns
// exactly one result transaction for each, via the queue and the result register. Every
// transaction is one time tick or one command (start, stop, write byte, read byte); the bus
// sequencer updates its phase state once per transaction; the queue between it and the front
// lets input and result sides stall independently. The phase_length register resets to 20;
// the user must write it via the cfg channel only while idle; the engine does not check it.
module i2c_master_byte_engine import i2cm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = I2CM_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  i2cm_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output i2cm_out_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic        cfg_we;
    logic [7:0]  phase_len_q_reg;
    logic        q_full, q_push, q_pop, q_valid;
    i2cm_entry_t q_in, q_head;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_len_q_reg <= PHASE_LEN_RESET;
        end else if (cfg_we) begin
            phase_len_q_reg <= cfg_data;
        end
    end

    i2cm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    i2cm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .phase_len (phase_len_q_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ tb/i2c_master_byte_engine_checker.sv @@
// Checker for the I2C master byte engine: predicts the line drives and command status
// of each input transaction and compares them with the result channel.
// Depends on i2cm_pkg for the transaction structs, command and line action codes.
`timescale 1ns / 1ps
module i2c_master_byte_engine_checker import i2cm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  i2cm_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  i2cm_out_t   m_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int unsigned error_count,
    output int unsigned results_owed
);

    localparam int REPORT_LIMIT    = 10;
    localparam int LAST_PHASE_DONE = -1;

    logic [7:0]  phase_len;
    logic        scl_drv;
    logic        sda_drv;
    logic [2:0]  op_q;
    logic [2:0]  step_q;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  hold_cnt;
    logic        ack_flag;
    logic        nack_flag;
    i2cm_out_t   line_expect[$];
    int unsigned mismatches;

    function automatic logic [2:0] phase_action(input logic [2:0] op, input logic [2:0] st);
        case ({op, st})
            {CMD_START, 3'd1}, {CMD_STOP, 3'd2}, {CMD_WRITE, 3'd1}, {CMD_WRITE, 3'd4},
            {CMD_READ, 3'd1}, {CMD_READ, 3'd4}: return ACT_SCL_H;
            {CMD_START, 3'd3}, {CMD_STOP, 3'd0}, {CMD_WRITE, 3'd2}, {CMD_WRITE, 3'd5},
            {CMD_READ, 3'd2}, {CMD_READ, 3'd5}: return ACT_SCL_L;
            {CMD_START, 3'd2}, {CMD_STOP, 3'd1}: return ACT_SDA_L;
            {CMD_WRITE, 3'd0}: return ACT_SDA_BIT;
            {CMD_READ, 3'd3}: return ACT_SDA_ACK;
            default: return ACT_SDA_H;
        endcase
    endfunction

    function automatic int phase_total(input logic [2:0] op);
        case (op)
            CMD_START, CMD_STOP: return 4;
            CMD_WRITE: return 6;
            CMD_READ: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] hold_span();
        return (phase_len == 8'd0) ? 8'd1 : phase_len;
    endfunction

    function automatic void enter_phase(input logic [2:0] st);
        logic [2:0] act;
        step_q = st;
        act = phase_action(op_q, st);
        case (act)
            ACT_SDA_H: sda_drv = 1'b0;
            ACT_SDA_L: sda_drv = 1'b1;
            ACT_SCL_H: scl_drv = 1'b0;
            ACT_SCL_L: scl_drv = 1'b1;
            ACT_SDA_BIT: sda_drv = ~shreg[7];
            default: sda_drv = ~nack_flag;
        endcase
        hold_cnt = (act == ACT_SCL_H) ? 8'd0 : hold_span();
    endfunction

    // Ends the current phase, shifting or sampling where the phase calls for it.
    function automatic int close_phase(input logic sda);
        int nxt;
        nxt = int'(step_q) + 1;
        if (op_q == CMD_WRITE) begin
            if (step_q == 3'd0) shreg = shreg << 1;
            if (step_q == 3'd2) begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 4'd8) nxt = 0;
            end
            if (step_q == 3'd4) ack_flag = ~sda;
        end else if (op_q == CMD_READ) begin
            if (step_q == 3'd1) shreg = {shreg[6:0], sda};
            if (step_q == 3'd2) begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 4'd8) nxt = 1;
            end
        end
        if (nxt >= phase_total(op_q)) nxt = LAST_PHASE_DONE;
        return nxt;
    endfunction

    function automatic i2cm_out_t bus_step(input i2cm_in_t t);
        i2cm_out_t r;
        logic      is_cmd;
        int        nxt;
        r = '0;
        is_cmd = (t.cmd >= CMD_START) && (t.cmd <= CMD_READ);
        if (op_q != OP_IDLE) begin
            r.cmd_refused = is_cmd;
            if (phase_action(op_q, step_q) == ACT_SCL_H && hold_cnt == 8'd0 && t.scl_in) begin
                hold_cnt = hold_span();
            end
            if (hold_cnt != 8'd0) begin
                hold_cnt = hold_cnt - 8'd1;
                if (hold_cnt == 8'd0) begin
                    nxt = close_phase(t.sda_in);
                    if (nxt == LAST_PHASE_DONE) begin
                        r.done_res = 1'b1;
                        if (op_q == CMD_WRITE) r.ack_ok = ack_flag;
                        if (op_q == CMD_READ) r.read_byte = shreg;
                        op_q = OP_IDLE;
                        step_q = 3'd0;
                        bit_cnt = 4'd0;
                    end else begin
                        enter_phase(nxt[2:0]);
                    end
                end
            end
        end else if (is_cmd) begin
            op_q = t.cmd;
            bit_cnt = 4'd0;
            ack_flag = 1'b0;
            shreg = (t.cmd == CMD_WRITE) ? t.data_byte : 8'h00;
            if (t.cmd == CMD_READ) nack_flag = t.last_byte;
            enter_phase(3'd0);
        end
        r.scl_low = scl_drv;
        r.sda_low = sda_drv;
        r.busy_res = (op_q != OP_IDLE);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        i2cm_out_t want;
        if (!aresetn) begin
            phase_len = PHASE_LEN_RESET;
            scl_drv = 1'b0;
            sda_drv = 1'b0;
            op_q = OP_IDLE;
            step_q = 3'd0;
            bit_cnt = 4'd0;
            shreg = 8'h00;
            hold_cnt = 8'h00;
            ack_flag = 1'b0;
            nack_flag = 1'b0;
            line_expect.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) phase_len = cfg_data;
            if (m_valid && m_ready) begin
                if (line_expect.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: result transaction with nothing expected", $time);
                    end
                    mismatches++;
                end else begin
                    want = line_expect.pop_front();
                    if (m_data !== want) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("%0t: exp %b%b%b%b%b %h %b got %b%b%b%b%b %h %b",
                                     $time, want.scl_low, want.sda_low, want.busy_res,
                                     want.done_res, want.ack_ok, want.read_byte,
                                     want.cmd_refused, m_data.scl_low, m_data.sda_low,
                                     m_data.busy_res, m_data.done_res, m_data.ack_ok,
                                     m_data.read_byte, m_data.cmd_refused);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) line_expect.push_back(bus_step(s_data));
        end
        error_count <= mismatches;
        results_owed <= line_expect.size();
    end

endmodule

@@ tb/i2c_master_byte_engine_tb.sv @@
// Testbench top for the I2C master byte engine: clock, reset, bus command stimulus and
// the phase length register writes; the checker module does all prediction and comparison.
// Depends on i2cm_pkg, i2c_master_byte_engine and i2c_master_byte_engine_checker.
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         RANDOM_ITEMS  = 300;
    localparam int         PLAN_LEN      = 4;
    localparam int         DRAIN_PHASES  = 28;
    localparam int         FINAL_TICKS   = 24;
    localparam int         IN_W          = $bits(i2cm_in_t);

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    i2cm_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    i2cm_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    int unsigned error_count;
    int unsigned results_owed;
    logic        steady    = 1'b0;
    logic [7:0]  cur_len   = PHASE_LEN_RESET;
    int          items_sent = 0;
    int          quiet      = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    i2c_master_byte_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2c_master_byte_engine_checker bus_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("i2c_master_byte_engine_tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int hspan();
        return (cur_len == 8'd0) ? 1 : int'(cur_len);
    endfunction

    function automatic int op_phases(input logic [2:0] cmd);
        case (cmd)
            CMD_START, CMD_STOP: return 4;
            CMD_WRITE: return 27;
            CMD_READ: return 21;
            default: return 0;
        endcase
    endfunction

    task automatic push_item(input i2cm_in_t t);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < 5) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Sends time ticks until enough transactions with SCL seen high have gone by to
    // cover the given number of phase items; SCL held low only ever adds a wait.
    task automatic run_ticks(input int need, input int sda_fix, input int stretch_pct,
                             input int refuse_pct);
        int       counted;
        int       sent;
        i2cm_in_t t;
        counted = 0;
        sent = 0;
        while (counted < need) begin
            t.cmd = CMD_TICK;
            if ($urandom_range(3) == 0) t.cmd = CMD_UNUSED_LO + 3'($urandom_range(2));
            if (sent + 1 <= need && $urandom_range(99) < refuse_pct) begin
                t.cmd = CMD_START + 3'($urandom_range(3));
            end
            t.data_byte = 8'($urandom);
            t.last_byte = 1'($urandom);
            t.scl_in = ($urandom_range(99) < stretch_pct) ? 1'b0 : 1'b1;
            t.sda_in = (sda_fix < 0) ? 1'($urandom) : 1'(sda_fix);
            push_item(t);
            sent++;
            if (t.scl_in) counted++;
        end
    endtask

    task automatic bus_op(input logic [2:0] cmd, input logic [7:0] data, input logic last,
                          input int sda_fix, input int stretch_pct, input int refuse_pct);
        i2cm_in_t t;
        t.cmd = cmd;
        t.data_byte = data;
        t.last_byte = last;
        t.scl_in = 1'($urandom);
        t.sda_in = 1'($urandom);
        push_item(t);
        run_ticks(op_phases(cmd) * hspan(), sda_fix, stretch_pct, refuse_pct);
    endtask

    task automatic random_transfer();
        int   nbytes;
        int   k;
        logic rd;
        nbytes = $urandom_range(1, 2);
        rd = 1'($urandom);
        bus_op(CMD_START, 8'($urandom), 1'($urandom), -1, 10, 5);
        bus_op(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 10, 5);
        for (k = 0; k < nbytes; k++) begin
            if (rd) bus_op(CMD_READ, 8'($urandom), (k == nbytes - 1), -1, 10, 5);
            else bus_op(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 10, 5);
        end
        if ($urandom_range(7) != 0) bus_op(CMD_STOP, 8'($urandom), 1'($urandom), -1, 10, 5);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) push_item(IN_W'($urandom));
            run_ticks(DRAIN_PHASES * hspan(), -1, 0, 0);
        end
    endtask

    task automatic set_length(input logic [7:0] v, input logic drain);
        if (drain) run_ticks(DRAIN_PHASES * hspan(), -1, 0, 0);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_len = v;
    endtask

    initial begin
        int         mark;
        logic [7:0] plan [PLAN_LEN];
        plan = '{8'd1, 8'd2, 8'd0, 8'd1};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        bus_op(CMD_START, 8'h00, 1'b0, -1, 10, 0);
        set_length(8'd1, 1'b0);

        push_item('{cmd: CMD_TICK, data_byte: 8'h00, last_byte: 1'b0, scl_in: 1'b0,
                    sda_in: 1'b0});
        push_item('{cmd: CMD_UNUSED_LO + 3'd2, data_byte: 8'hFF, last_byte: 1'b1,
                    scl_in: 1'b1, sda_in: 1'b1});
        bus_op(CMD_START, 8'h00, 1'b0, 1, 30, 40);
        bus_op(CMD_WRITE, 8'hFF, 1'b1, 0, 30, 40);
        bus_op(CMD_WRITE, 8'h00, 1'b0, 1, 0, 0);
        bus_op(CMD_READ, 8'h00, 1'b0, 1, 0, 0);
        bus_op(CMD_READ, 8'hFF, 1'b1, 0, 0, 0);
        bus_op(CMD_STOP, 8'h5A, 1'b0, -1, 30, 40);

        mark = items_sent;
        foreach (plan[p]) begin
            set_length(plan[p], 1'b0);
            steady <= (p == 1);
            do random_transfer();
            while (items_sent < mark + (p + 1) * RANDOM_ITEMS / PLAN_LEN);
        end
        steady <= 1'b0;

        set_length(8'd255, 1'b0);
        push_item('{cmd: CMD_START, data_byte: 8'h00, last_byte: 1'b0, scl_in: 1'b1,
                    sda_in: 1'b1});
        run_ticks(FINAL_TICKS, -1, 10, 20);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("i2c_master_byte_engine_tb: done, clean");
        end else begin
            $display("i2c_master_byte_engine_tb: done, errors");
        end
        $finish;
    end

endmodule
